/* hw/rtl/epoch_seconds_to_utc_date_defines.svh */
// Assertion macros for the epoch-to-date converter.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef EPOCH_SECONDS_TO_UTC_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_DEFINES_SVH

// Condition and consequence in the same cycle.
`define ES2D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define ES2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/es2d_pkg.sv */
// Shared types, constants and month tables for the epoch-to-date converter.
// No dependencies.
`default_nettype none

package es2d_pkg;

  // First non-negative time whose day count from 1601 needs more than 32 bits.
  localparam logic [62:0] SecLimit = 63'd371073529900800;

  // Seconds-to-days split: 86400 = 128 * 675, the 675 part by long division.
  localparam int unsigned LowBits          = 7;
  localparam int unsigned HeadW            = 7;
  localparam int unsigned RemW             = 10;
  localparam int unsigned DivStages        = 5;
  localparam int unsigned DivStepsPerStage = 7;
  localparam int unsigned DivWorkW         = DivStages * DivStepsPerStage;
  localparam logic [RemW:0] SecDivisor     = 11'd675;
  localparam logic [16:0] SecsPerDay       = 17'd86400;
  localparam logic [31:0] MaxDays1970      = 32'd4294832521;

  localparam logic [12:0] SecsPerHour      = 13'd3600;
  localparam logic [6:0]  SecsPerMin       = 7'd60;

  localparam logic [31:0] Days1601To1970   = 32'd134774;
  localparam logic [18:0] Days400Y         = 19'd146097;
  localparam logic [17:0] Days100Y         = 18'd36524;
  localparam logic [11:0] Days4Y           = 12'd1461;
  localparam logic [10:0] Days1Y           = 11'd365;
  localparam logic [24:0] YearOffset       = 25'd299;   // 1900 - 1601

  localparam logic [8:0] CumNormal [13] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                            9'd181, 9'd212, 9'd243, 9'd273, 9'd304,
                                            9'd334, 9'd365};
  localparam logic [8:0] CumLeap   [13] = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
                                            9'd182, 9'd213, 9'd244, 9'd274, 9'd305,
                                            9'd335, 9'd366};

  typedef struct packed {
    logic        bad;
    logic [31:0] days_1970;
    logic [16:0] secday;
  } split_t;

endpackage

`default_nettype wire

/* hw/rtl/epoch_seconds_to_utc_date.sv */
// Converts a signed 64-bit count of seconds since 1970-01-01 UTC into the
// proleptic Gregorian date and time of day. One item enters per clock while
// the output is taken or the pipeline has room. Six stages split seconds into
// days and second of day, seven stages turn the day count into year and month,
// and one output register adds the day of month and holds the result. The
// stage count is set by the long-division stages for 86400 and the 400-year
// cycle. Every stage loads whenever it or the stage after it is free, so a
// stalled output fills the pipeline before in_ready falls. A negative time, or
// one whose day count from 1601 would not fit in 32 bits, returns valid_res low
// with every other field zero.
//
// Top level of the epoch-to-date converter.
// Depends on es2d_pkg, es2d_day_split and the assertion macro header.
`default_nettype none
`include "epoch_seconds_to_utc_date_defines.svh"

module epoch_seconds_to_utc_date
  import es2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] epoch_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               valid_res,
  output logic [23:0]        year_since_1900,
  output logic [3:0]         month,
  output logic [4:0]         day_of_month,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second,
  output logic [2:0]         weekday,
  output logic [8:0]         day_of_year
);

  localparam int unsigned NumStages   = 8;
  localparam int unsigned Q400Steps1  = 8;
  localparam int unsigned Q400Steps2  = 7;
  localparam logic [24:0] DaysYears400 = 25'd400;
  localparam logic [24:0] DaysYears100 = 25'd100;
  localparam logic [24:0] DaysYears4   = 25'd4;
  localparam logic [5:0]  LastQuad     = 6'd24;   // quad that ends on a century year

  typedef struct packed {
    logic        bad;
    logic [31:0] d;         // days since 1601-01-01
    logic [17:0] r400;
    logic [14:0] w400;
    logic [24:0] yacc;
    logic [1:0]  c100;
    logic [15:0] rem100;
    logic [5:0]  q4;
    logic [10:0] rem4;
    logic [1:0]  y1;
    logic [8:0]  yday;
    logic [23:0] year;
    logic        leap;
    logic [3:0]  mon;
    logic [8:0]  base;
    logic [4:0]  dom;
    logic [4:0]  hour;
    logic [11:0] rem3600;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } cal_t;

  logic                 split_valid;
  logic                 split_ready;
  split_t               split_data;
  cal_t                 cal      [NumStages];
  cal_t                 cal_next [NumStages];
  logic [NumStages-1:0] v;
  logic [NumStages-1:0] v_in;
  logic [NumStages-1:0] en;

  // (x + 1) mod 7, folding octal digits since 8 = 1 mod 7.
  function automatic logic [2:0] mod7_of_next(input logic [31:0] x);
    logic [32:0] xp;
    logic [6:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    xp = {1'b0, x};
    s1 = 7'd1;
    for (int i = 0; i < 11; i++) begin
      s1 = s1 + 7'(xp[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]) + 4'(s1[6]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[2:0];
  endfunction

  es2d_day_split u_split (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .epoch_seconds(epoch_seconds),
    .out_valid    (split_valid),
    .out_ready    (split_ready),
    .out_data     (split_data)
  );

  always_comb begin
    en[NumStages-1] = !v[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign split_ready = en[0];
  assign v_in        = {v[NumStages-2:0], split_valid};

  always_comb begin
    cal_t        s;
    logic [5:0]  hw;
    logic [12:0] t3600;
    logic [5:0]  mr;
    logic [6:0]  mw;
    logic [6:0]  t60;
    logic [18:0] t400;
    logic        ge1;
    logic        ge2;
    logic        ge3;
    logic [17:0] sub18;
    logic [17:0] diff18;
    logic [11:0] t1461;
    logic [10:0] r4;
    logic [5:0]  qw;
    logic [10:0] sub11;
    logic [10:0] diff11;
    logic [24:0] ysum;
    logic [3:0]  cnt;
    logic [8:0]  dsum;

    // Day count from 1601 and hour of day.
    s          = '0;
    s.bad      = split_data.bad;
    s.d        = split_data.days_1970 + Days1601To1970;
    s.rem3600  = {1'b0, split_data.secday[16:6]};
    hw         = split_data.secday[5:0];
    for (int j = 0; j < 6; j++) begin
      t3600 = {s.rem3600, hw[5]};
      hw    = {hw[4:0], t3600 >= SecsPerHour};
      if (t3600 >= SecsPerHour) begin
        t3600 = t3600 - SecsPerHour;
      end
      s.rem3600 = t3600[11:0];
    end
    s.hour      = hw[4:0];
    cal_next[0] = s;

    // First part of the 400-year division; minute, second, weekday.
    s      = cal[0];
    s.r400 = {1'b0, s.d[31:15]};
    s.w400 = s.d[14:0];
    for (int j = 0; j < Q400Steps1; j++) begin
      t400   = {s.r400, s.w400[14]};
      s.w400 = {s.w400[13:0], t400 >= Days400Y};
      if (t400 >= Days400Y) begin
        t400 = t400 - Days400Y;
      end
      s.r400 = t400[17:0];
    end
    mr = {1'b0, s.rem3600[11:7]};
    mw = s.rem3600[6:0];
    for (int j = 0; j < 7; j++) begin
      t60 = {mr, mw[6]};
      mw  = {mw[5:0], t60 >= SecsPerMin};
      if (t60 >= SecsPerMin) begin
        t60 = t60 - SecsPerMin;
      end
      mr = t60[5:0];
    end
    s.minute    = mw[5:0];
    s.second    = mr;
    s.weekday   = mod7_of_next(s.d);
    cal_next[1] = s;

    // Rest of the 400-year division.
    s = cal[1];
    for (int j = 0; j < Q400Steps2; j++) begin
      t400   = {s.r400, s.w400[14]};
      s.w400 = {s.w400[13:0], t400 >= Days400Y};
      if (t400 >= Days400Y) begin
        t400 = t400 - Days400Y;
      end
      s.r400 = t400[17:0];
    end
    cal_next[2] = s;

    // Centuries, clamped to three so the last day of a 400-year cycle stays in it.
    s   = cal[2];
    ge1 = s.r400 >= Days100Y;
    ge2 = s.r400 >= 18'(2 * Days100Y);
    ge3 = s.r400 >= 18'(3 * Days100Y);
    s.c100 = 2'(ge1) + 2'(ge2) + 2'(ge3);
    if (ge3) begin
      sub18 = 18'(3 * Days100Y);
    end else if (ge2) begin
      sub18 = 18'(2 * Days100Y);
    end else if (ge1) begin
      sub18 = Days100Y;
    end else begin
      sub18 = '0;
    end
    diff18      = s.r400 - sub18;
    s.rem100    = diff18[15:0];
    s.yacc      = 25'(s.w400) * DaysYears400 + 25'(s.c100) * DaysYears100;
    cal_next[3] = s;

    // Four-year spans.
    s  = cal[3];
    r4 = {1'b0, s.rem100[15:6]};
    qw = s.rem100[5:0];
    for (int j = 0; j < 6; j++) begin
      t1461 = {r4, qw[5]};
      qw    = {qw[4:0], t1461 >= Days4Y};
      if (t1461 >= Days4Y) begin
        t1461 = t1461 - Days4Y;
      end
      r4 = t1461[10:0];
    end
    s.q4        = qw;
    s.rem4      = r4;
    cal_next[4] = s;

    // Single years, clamped to three for the leap day; year and leap flag.
    s   = cal[4];
    ge1 = s.rem4 >= Days1Y;
    ge2 = s.rem4 >= 11'(2 * Days1Y);
    ge3 = s.rem4 >= 11'(3 * Days1Y);
    s.y1 = 2'(ge1) + 2'(ge2) + 2'(ge3);
    if (ge3) begin
      sub11 = 11'(3 * Days1Y);
    end else if (ge2) begin
      sub11 = 11'(2 * Days1Y);
    end else if (ge1) begin
      sub11 = Days1Y;
    end else begin
      sub11 = '0;
    end
    diff11 = s.rem4 - sub11;
    s.yday = diff11[8:0];
    // Fourth year of a quad is leap, except a century year outside the fourth century.
    s.leap      = (s.y1 == 2'd3) && ((s.q4 != LastQuad) || (s.c100 == 2'd3));
    ysum        = s.yacc + 25'(s.q4) * DaysYears4 + 25'(s.y1) - YearOffset;
    s.year      = ysum[23:0];
    cal_next[5] = s;

    // Month from the cumulative table.
    s   = cal[5];
    cnt = '0;
    for (int k = 1; k < 12; k++) begin
      if (s.yday >= (s.leap ? CumLeap[k] : CumNormal[k])) begin
        cnt = cnt + 4'd1;
      end
    end
    s.mon       = cnt;
    s.base      = s.leap ? CumLeap[cnt] : CumNormal[cnt];
    cal_next[6] = s;

    // Day of month; a rejected time reads as all zeros.
    s     = cal[6];
    dsum  = s.yday - s.base + 9'd1;
    s.dom = dsum[4:0];
    if (s.bad) begin
      s.year    = '0;
      s.mon     = '0;
      s.dom     = '0;
      s.hour    = '0;
      s.minute  = '0;
      s.second  = '0;
      s.weekday = '0;
      s.yday    = '0;
    end
    cal_next[7] = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (en & v_in) | (~en & v);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        cal[k] <= cal_next[k];
      end
    end
  end

  assign out_valid       = v[NumStages-1];
  assign valid_res       = !cal[NumStages-1].bad;
  assign year_since_1900 = cal[NumStages-1].year;
  assign month           = cal[NumStages-1].mon;
  assign day_of_month    = cal[NumStages-1].dom;
  assign hour            = cal[NumStages-1].hour;
  assign minute          = cal[NumStages-1].minute;
  assign second          = cal[NumStages-1].second;
  assign weekday         = cal[NumStages-1].weekday;
  assign day_of_year     = cal[NumStages-1].yday;

  `ES2D_ASSERT_SAME(a_reject_zero, out_valid && !valid_res,
                    year_since_1900 == 24'd0 && month == 4'd0 && day_of_month == 5'd0 &&
                    hour == 5'd0 && minute == 6'd0 && second == 6'd0 &&
                    weekday == 3'd0 && day_of_year == 9'd0,
                    "rejected time carries nonzero fields")
  `ES2D_ASSERT_SAME(a_field_ranges, out_valid && valid_res,
                    month <= 4'd11 && day_of_month != 5'd0 && hour <= 5'd23 &&
                    minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6 &&
                    year_since_1900 >= 24'd70,
                    "converted field out of range")
  `ES2D_ASSERT_SAME(a_last_leap_day, out_valid && valid_res && day_of_year == 9'd365,
                    month == 4'd11 && day_of_month == 5'd31,
                    "day 365 of a leap year is not December 31")

endmodule

`default_nettype wire

/* hw/rtl/es2d_day_split.sv */
// Pipelined split of a seconds count into whole days and second of day.
// Depends on es2d_pkg and the assertion macro header.
`default_nettype none
`include "epoch_seconds_to_utc_date_defines.svh"

module es2d_day_split
  import es2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] epoch_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output split_t             out_data
);

  localparam int unsigned NumStages = DivStages + 1;

  typedef struct packed {
    logic                bad;
    logic [RemW-1:0]     rem;
    logic [DivWorkW-1:0] work;   // dividend bits shift out, quotient bits shift in
    logic [LowBits-1:0]  low;
  } div_t;

  div_t                 stg      [NumStages];
  div_t                 stg_next [NumStages];
  logic [NumStages-1:0] v;
  logic [NumStages-1:0] v_in;
  logic [NumStages-1:0] en;

  // A stage loads when it is empty or its successor moves, so bubbles collapse.
  always_comb begin
    en[NumStages-1] = !v[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_in = {v[NumStages-2:0], in_valid};

  always_comb begin
    logic [RemW:0] trial;
    div_t          s;
    stg_next[0].bad  = epoch_seconds[63] || (epoch_seconds[62:0] >= SecLimit);
    stg_next[0].rem  = {{(RemW - HeadW){1'b0}}, epoch_seconds[LowBits + DivWorkW +: HeadW]};
    stg_next[0].work = epoch_seconds[LowBits +: DivWorkW];
    stg_next[0].low  = epoch_seconds[LowBits-1:0];
    for (int k = 1; k < NumStages; k++) begin
      s = stg[k-1];
      for (int j = 0; j < DivStepsPerStage; j++) begin
        trial  = {s.rem, s.work[DivWorkW-1]};
        s.work = {s.work[DivWorkW-2:0], trial >= SecDivisor};
        if (trial >= SecDivisor) begin
          trial = trial - SecDivisor;
        end
        s.rem = trial[RemW-1:0];
      end
      stg_next[k] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (en & v_in) | (~en & v);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  assign in_ready           = en[0];
  assign out_valid          = v[NumStages-1];
  assign out_data.bad       = stg[NumStages-1].bad;
  assign out_data.days_1970 = stg[NumStages-1].work[31:0];
  assign out_data.secday    = {stg[NumStages-1].rem, stg[NumStages-1].low};

  `ES2D_ASSERT_SAME(a_block_only_when_full, !in_ready, (&v) && !out_ready,
                    "input blocked while the split pipeline has room")
  `ES2D_ASSERT_SAME(a_secday_range, out_valid, out_data.secday < SecsPerDay,
                    "second of day out of range")
  `ES2D_ASSERT_SAME(a_days_range, out_valid && !out_data.bad,
                    out_data.days_1970 <= MaxDays1970,
                    "accepted time gives a day count beyond 32 bits")

endmodule

`default_nettype wire
